### src/stq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package stq_pkg;

	localparam int unsigned DEPTH_DEF     = 16;
	localparam int unsigned TIME_BITS_DEF = 64;

	localparam int unsigned OP_W    = 2;
	localparam int unsigned DELAY_W = 32;
	localparam int unsigned TID_W   = 4;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned TPM_W   = 16;
	localparam int unsigned SPAN_W  = DELAY_W + TPM_W;
	localparam int unsigned IN_W    = 40;
	localparam int unsigned OUT_W   = 8;
	localparam int unsigned ADDR_W  = 3;
	localparam int unsigned DATA_W  = 32;

	localparam logic [TPM_W-1:0] TPM_RESET = 16'd1000;
	localparam logic             REG_TPM   = 1'b0;

	localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
	localparam logic [OP_W-1:0] OP_CREATE = 2'd1;
	localparam logic [OP_W-1:0] OP_CANCEL = 2'd2;

	localparam logic [KIND_W-1:0] KIND_CREATED = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FULL    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CANCEL  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd3;

	localparam logic [1:0] CELL_HOLD   = 2'd0;
	localparam logic [1:0] CELL_INSERT = 2'd1;
	localparam logic [1:0] CELL_REMOVE = 2'd2;
	localparam logic [1:0] CELL_POP    = 2'd3;

	typedef struct packed {
		logic [1:0]       op;
		logic [TID_W-1:0] tid;
	} cell_ctl_t;

endpackage
`default_nettype wire

### src/stq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module stq_cell #(
	parameter int unsigned TIME_BITS = stq_pkg::TIME_BITS_DEF,
	parameter int unsigned ID_W      = $clog2(stq_pkg::DEPTH_DEF),
	parameter int unsigned IDX       = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  stq_pkg::cell_ctl_t    ctl,
	input  logic [TIME_BITS-1:0]  new_dl,
	input  logic [ID_W-1:0]       new_own,
	input  logic [ID_W-1:0]       rm_pos,
	input  logic                  prev_gt,
	input  logic                  prev_valid,
	input  logic [TIME_BITS-1:0]  prev_dl,
	input  logic [ID_W-1:0]       prev_own,
	input  logic                  next_valid,
	input  logic [TIME_BITS-1:0]  next_dl,
	input  logic [ID_W-1:0]       next_own,
	output logic                  valid,
	output logic [TIME_BITS-1:0]  dl,
	output logic [ID_W-1:0]       own,
	output logic                  gt,
	output logic                  match
);
	import stq_pkg::*;

	localparam int unsigned CMP_W = (ID_W > TID_W) ? ID_W : TID_W;
	localparam logic [ID_W-1:0] MY_POS = ID_W'(IDX);

	logic                 valid_q;
	logic [TIME_BITS-1:0] dl_q;
	logic [ID_W-1:0]      own_q;
	logic                 take_new;
	logic                 take_prev;
	logic                 take_next;

	assign gt    = valid_q && (new_dl > dl_q);
	assign match = valid_q && (CMP_W'(own_q) == CMP_W'(ctl.tid));
	assign valid = valid_q;
	assign dl    = dl_q;
	assign own   = own_q;

	always_comb begin
		take_new  = 1'b0;
		take_prev = 1'b0;
		take_next = 1'b0;
		unique case (ctl.op)
			CELL_INSERT: begin
				take_new  = !gt && prev_gt;
				take_prev = !gt && !prev_gt;
			end
			CELL_REMOVE: take_next = (MY_POS >= rm_pos);
			CELL_POP:    take_next = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_new) begin
			valid_q <= 1'b1;
		end else if (take_prev) begin
			valid_q <= prev_valid;
		end else if (take_next) begin
			valid_q <= next_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_new) begin
			dl_q  <= new_dl;
			own_q <= new_own;
		end else if (take_prev) begin
			dl_q  <= prev_dl;
			own_q <= prev_own;
		end else if (take_next) begin
			dl_q  <= next_dl;
			own_q <= next_own;
		end
	end

endmodule
`default_nettype wire

### src/sorted_timer_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// Deadline-ordered timer queue built as a row of DEPTH cells, each holding one
// timer (deadline, owner id) with the earliest deadline in cell 0. Every input
// transfer is handled alone: a tick checks the head and then pops expired
// entries, one head entry per cycle while the output register is free; a
// create runs operand latch, 32x16 multiply, saturating add and insert into
// the row, or answers queue full when the queue is full; a cancel runs match
// search, position encode, remove. Unknown opcodes are taken and dropped. Each
// result also waits for m_tready while the output register is still full.
// A finished result sits in the output register while the next input transfer
// is taken. ticks_per_ms is written through the APB port at byte address 0.
// No clearing pass is needed after reset.
module sorted_timer_queue #(
	parameter int unsigned DEPTH     = stq_pkg::DEPTH_DEF,
	parameter int unsigned TIME_BITS = stq_pkg::TIME_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// opcode[1:0], delay_ms[33:2], timer_id[37:34], zero[39:38]
	input  logic [stq_pkg::IN_W-1:0]    s_tdata,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// kind[1:0], timer_ident[5:2], found[6], zero[7]
	output logic [stq_pkg::OUT_W-1:0]   m_tdata,
	output logic                        m_tlast,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [stq_pkg::ADDR_W-1:0]  paddr,
	input  logic [stq_pkg::DATA_W-1:0]  pwdata,
	output logic [stq_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import stq_pkg::*;

	localparam int unsigned ID_W  = $clog2(DEPTH);
	localparam int unsigned SUM_W = ((TIME_BITS > SPAN_W) ? TIME_BITS : SPAN_W) + 1;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MUL   = 4'd1;
	localparam logic [3:0] ST_ADD   = 4'd2;
	localparam logic [3:0] ST_INS   = 4'd3;
	localparam logic [3:0] ST_FULL  = 4'd4;
	localparam logic [3:0] ST_CAN_A = 4'd5;
	localparam logic [3:0] ST_CAN_B = 4'd6;
	localparam logic [3:0] ST_TICK  = 4'd7;
	localparam logic [3:0] ST_FIRE  = 4'd8;

	logic [3:0]           state_q, state_d;
	logic [TPM_W-1:0]     tpm_q;
	logic [TIME_BITS-1:0] now_q;
	logic [DEPTH-1:0]     in_use_q;
	logic [DELAY_W-1:0]   delay_q;
	logic [TID_W-1:0]     tid_q;
	logic [SPAN_W-1:0]    span_s1;
	logic [TIME_BITS-1:0] when_q;
	logic [ID_W-1:0]      new_id_q;
	logic [ID_W-1:0]      pos_q;
	logic                 found_q;
	logic                 out_valid_q;
	logic [KIND_W-1:0]    out_kind_q;
	logic [TID_W-1:0]     out_ident_q;
	logic                 out_found_q;
	logic                 out_last_q;

	logic [OP_W-1:0]      in_op;
	logic                 in_xfer;
	logic                 out_free;
	logic                 cfg_wr;
	logic [SUM_W-1:0]     sum_w;
	logic [ID_W-1:0]      free_id;
	logic [ID_W-1:0]      pos_w;
	logic                 found_w;
	logic                 full_w;

	logic                 emit;
	logic [KIND_W-1:0]    e_kind;
	logic [TID_W-1:0]     e_ident;
	logic                 e_found;
	logic                 e_last;
	logic                 set_use;
	logic                 clr_use;
	logic [ID_W-1:0]      clr_idx;
	cell_ctl_t            ctl;

	logic                 c_valid [DEPTH];
	logic [TIME_BITS-1:0] c_dl    [DEPTH];
	logic [ID_W-1:0]      c_own   [DEPTH];
	logic                 c_gt    [DEPTH];
	logic                 c_match [DEPTH];
	logic                 p_gt    [DEPTH];
	logic                 p_valid [DEPTH];
	logic [TIME_BITS-1:0] p_dl    [DEPTH];
	logic [ID_W-1:0]      p_own   [DEPTH];
	logic                 n_valid [DEPTH];
	logic [TIME_BITS-1:0] n_dl    [DEPTH];
	logic [ID_W-1:0]      n_own   [DEPTH];

	assign in_op    = s_tdata[OP_W-1:0];
	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign full_w   = c_valid[DEPTH-1];

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_TPM) ? DATA_W'(tpm_q) : '0;

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {1'b0, out_found_q, out_ident_q, out_kind_q};

	assign sum_w = SUM_W'(now_q) + SUM_W'(span_s1);

	for (genvar i = 0; i < DEPTH; i++) begin : g_row
		if (i == 0) begin : g_head
			assign p_gt[i]    = 1'b1;
			assign p_valid[i] = 1'b0;
			assign p_dl[i]    = '0;
			assign p_own[i]   = '0;
		end else begin : g_mid
			assign p_gt[i]    = c_gt[i-1];
			assign p_valid[i] = c_valid[i-1];
			assign p_dl[i]    = c_dl[i-1];
			assign p_own[i]   = c_own[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign n_valid[i] = 1'b0;
			assign n_dl[i]    = '0;
			assign n_own[i]   = '0;
		end else begin : g_body
			assign n_valid[i] = c_valid[i+1];
			assign n_dl[i]    = c_dl[i+1];
			assign n_own[i]   = c_own[i+1];
		end

		stq_cell #(
			.TIME_BITS (TIME_BITS),
			.ID_W      (ID_W),
			.IDX       (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.new_dl     (when_q),
			.new_own    (new_id_q),
			.rm_pos     (pos_q),
			.prev_gt    (p_gt[i]),
			.prev_valid (p_valid[i]),
			.prev_dl    (p_dl[i]),
			.prev_own   (p_own[i]),
			.next_valid (n_valid[i]),
			.next_dl    (n_dl[i]),
			.next_own   (n_own[i]),
			.valid      (c_valid[i]),
			.dl         (c_dl[i]),
			.own        (c_own[i]),
			.gt         (c_gt[i]),
			.match      (c_match[i])
		);
	end

	always_comb begin
		free_id = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_id = ID_W'(i);
			end
		end
	end

	always_comb begin
		pos_w   = '0;
		found_w = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			if (c_match[i]) begin
				pos_w   = pos_w | ID_W'(i);
				found_w = 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		emit    = 1'b0;
		e_kind  = KIND_CREATED;
		e_ident = '0;
		e_found = 1'b0;
		e_last  = 1'b1;
		set_use = 1'b0;
		clr_use = 1'b0;
		clr_idx = c_own[0];
		ctl.op  = CELL_HOLD;
		ctl.tid = tid_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					unique case (in_op)
						OP_TICK:   state_d = ST_TICK;
						OP_CREATE: state_d = full_w ? ST_FULL : ST_MUL;
						OP_CANCEL: state_d = ST_CAN_A;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_MUL: state_d = ST_ADD;
			ST_ADD: state_d = ST_INS;
			ST_INS: begin
				if (out_free) begin
					emit    = 1'b1;
					e_kind  = KIND_CREATED;
					e_ident = TID_W'(new_id_q);
					ctl.op  = CELL_INSERT;
					set_use = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_FULL: begin
				if (out_free) begin
					emit    = 1'b1;
					e_kind  = KIND_FULL;
					state_d = ST_IDLE;
				end
			end
			ST_CAN_A: state_d = ST_CAN_B;
			ST_CAN_B: begin
				if (out_free) begin
					emit    = 1'b1;
					e_kind  = KIND_CANCEL;
					e_ident = tid_q;
					e_found = found_q;
					if (found_q) begin
						ctl.op  = CELL_REMOVE;
						clr_use = 1'b1;
						clr_idx = ID_W'(tid_q);
					end
					state_d = ST_IDLE;
				end
			end
			ST_TICK: state_d = (c_valid[0] && (c_dl[0] < now_q)) ? ST_FIRE : ST_IDLE;
			ST_FIRE: begin
				if (out_free) begin
					emit    = 1'b1;
					e_kind  = KIND_EXPIRED;
					e_ident = TID_W'(c_own[0]);
					e_last  = !(c_valid[1] && (c_dl[1] <= now_q));
					ctl.op  = CELL_POP;
					clr_use = 1'b1;
					if (e_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			tpm_q       <= TPM_RESET;
			now_q       <= '0;
			in_use_q    <= '0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr && (paddr[2] == REG_TPM)) begin
				tpm_q <= pwdata[TPM_W-1:0];
			end
			if (in_xfer && (in_op == OP_TICK) && !(&now_q)) begin
				now_q <= now_q + 1'b1;
			end
			if (set_use) begin
				in_use_q[new_id_q] <= 1'b1;
			end
			if (clr_use) begin
				in_use_q[clr_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			delay_q  <= s_tdata[OP_W +: DELAY_W];
			tid_q    <= s_tdata[OP_W + DELAY_W +: TID_W];
			new_id_q <= free_id;
		end
		if (state_q == ST_MUL) begin
			span_s1 <= delay_q * tpm_q;
		end
		if (state_q == ST_ADD) begin
			when_q <= (|sum_w[SUM_W-1:TIME_BITS]) ? '1 : sum_w[TIME_BITS-1:0];
		end
		if (state_q == ST_CAN_A) begin
			pos_q   <= pos_w;
			found_q <= found_w;
		end
		if (emit) begin
			out_kind_q  <= e_kind;
			out_ident_q <= e_ident;
			out_found_q <= e_found;
			out_last_q  <= e_last;
		end
	end

endmodule
`default_nettype wire

### src/stq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module stq_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic [stq_pkg::IN_W-1:0]   s_tdata,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic [stq_pkg::OUT_W-1:0]  m_tdata,
	input logic                       m_tlast,
	input logic                       m_tvalid,
	input logic                       m_tready
);
	import stq_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && ((s_tdata[1:0] == OP_TICK) ||
			(s_tdata[1:0] == OP_CREATE) || (s_tdata[1:0] == OP_CANCEL)) |=> !s_tready)
		else $error("input taken while an item is in work");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] != KIND_EXPIRED) |-> m_tlast)
		else $error("single result without last");

	a_found_cancel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[6] |-> (m_tdata[1:0] == KIND_CANCEL))
		else $error("found set outside a cancel answer");

	a_full_ident: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == KIND_FULL) |-> (m_tdata[5:2] == 4'd0))
		else $error("queue full result carries an id");

endmodule

bind sorted_timer_queue stq_checker u_stq_checker (.*);
`default_nettype wire
